// ===== design/servo_sweep_sequencer_top_defines.svh =====
// assertion macros for the servo sweep sequencer checker
// no dependencies; clocked on aclk, reset by aresetn (active low)
`ifndef SERVO_SWEEP_SEQUENCER_TOP_DEFINES_SVH
`define SERVO_SWEEP_SEQUENCER_TOP_DEFINES_SVH

// property checked outside reset
`define SSQ_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("servo sweep sequencer check failed");

// property checked at every edge, reset included
`define SSQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("servo sweep sequencer reset check failed");

`endif

// ===== design/ssq_pkg.sv =====
// shared types, codes, constants and helper functions of the servo sweep sequencer
// no dependencies
package ssq_pkg;

    localparam int TICKS_PER_STEP = 2;

    localparam logic [11:0] YAW_CENTER_RST   = 12'd1500;
    localparam logic [11:0] YAW_MIN_RST      = 12'd1000;
    localparam logic [11:0] YAW_MAX_RST      = 12'd2000;
    localparam logic [11:0] PITCH_CENTER_RST = 12'd1500;
    localparam logic [11:0] PITCH_MIN_RST    = 12'd1000;
    localparam logic [11:0] PITCH_MAX_RST    = 12'd2000;
    localparam logic [7:0]  SWEEP_STEP_RST   = 8'd10;
    localparam logic [9:0]  HOLD_STEPS_RST   = 10'd50;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_RECENTER = 2'd1,
        OP_DIRECT   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        CFG_YAW_CENTER   = 3'd0,
        CFG_YAW_MIN      = 3'd1,
        CFG_YAW_MAX      = 3'd2,
        CFG_PITCH_CENTER = 3'd3,
        CFG_PITCH_MIN    = 3'd4,
        CFG_PITCH_MAX    = 3'd5,
        CFG_SWEEP_STEP   = 3'd6,
        CFG_HOLD_STEPS   = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_HOLD_YAW    = 4'd0,
        PH_YAW_UP      = 4'd1,
        PH_YAW_DOWN    = 4'd2,
        PH_YAW_BACK    = 4'd3,
        PH_HOLD_MID    = 4'd4,
        PH_PITCH_UP    = 4'd5,
        PH_PITCH_DOWN  = 4'd6,
        PH_PITCH_BACK  = 4'd7,
        PH_HOLD_PITCH  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] yaw_request_us;
        logic [15:0] pitch_request_us;
    } ssq_in_t;

    typedef struct packed {
        logic [11:0] yaw_pulse_us;
        logic [11:0] pitch_pulse_us;
        logic [10:0] yaw_duty;
        logic [15:0] pitch_compare;
        logic        updated;
    } ssq_out_t;

    typedef struct packed {
        logic [11:0] yaw_center_us;
        logic [11:0] yaw_min_us;
        logic [11:0] yaw_max_us;
        logic [11:0] pitch_center_us;
        logic [11:0] pitch_min_us;
        logic [11:0] pitch_max_us;
        logic [7:0]  sweep_step_us;
        logic [9:0]  hold_steps;
    } cfg_t;

    typedef struct packed {
        logic        done;
        logic [11:0] value;
    } move_t;

    // raise to lo first, then lower to hi, so lo > hi gives hi
    function automatic logic [11:0] clamp_us(logic [15:0] v, logic [11:0] lo,
                                             logic [11:0] hi);
        logic [15:0] t;
        t = v;
        if (t < {4'b0, lo}) t = {4'b0, lo};
        if (t > {4'b0, hi}) t = {4'b0, hi};
        return t[11:0];
    endfunction

    function automatic move_t move_up(logic [11:0] v, logic [7:0] step,
                                      logic [11:0] target);
        logic [12:0] sum;
        move_t       r;
        sum = {1'b0, v} + {5'b0, step};
        if (sum >= {1'b0, target}) begin
            r.done  = 1'b1;
            r.value = target;
        end else begin
            r.done  = 1'b0;
            r.value = sum[11:0];
        end
        return r;
    endfunction

    function automatic move_t move_down(logic [11:0] v, logic [7:0] step,
                                        logic [11:0] target);
        logic [11:0] diff;
        move_t       r;
        diff = v - {4'b0, step};
        // a negative difference is always at or below the target
        if ({4'b0, step} > v || diff <= target) begin
            r.done  = 1'b1;
            r.value = target;
        end else begin
            r.done  = 1'b0;
            r.value = diff;
        end
        return r;
    endfunction

endpackage

// ===== design/ssq_cfg_regs.sv =====
// configuration register bank of the servo sweep sequencer
// depends on ssq_pkg
module ssq_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  ssq_pkg::cfg_idx_t cfg_index,
    input  logic [11:0]       cfg_wdata,
    output ssq_pkg::cfg_t     cfg
);
    import ssq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_YAW_CENTER:   cfg_next.yaw_center_us   = cfg_wdata;
                CFG_YAW_MIN:      cfg_next.yaw_min_us      = cfg_wdata;
                CFG_YAW_MAX:      cfg_next.yaw_max_us      = cfg_wdata;
                CFG_PITCH_CENTER: cfg_next.pitch_center_us = cfg_wdata;
                CFG_PITCH_MIN:    cfg_next.pitch_min_us    = cfg_wdata;
                CFG_PITCH_MAX:    cfg_next.pitch_max_us    = cfg_wdata;
                CFG_SWEEP_STEP:   cfg_next.sweep_step_us   = cfg_wdata[7:0];
                CFG_HOLD_STEPS:   cfg_next.hold_steps      = cfg_wdata[9:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.yaw_center_us   <= YAW_CENTER_RST;
            cfg_reg.yaw_min_us      <= YAW_MIN_RST;
            cfg_reg.yaw_max_us      <= YAW_MAX_RST;
            cfg_reg.pitch_center_us <= PITCH_CENTER_RST;
            cfg_reg.pitch_min_us    <= PITCH_MIN_RST;
            cfg_reg.pitch_max_us    <= PITCH_MAX_RST;
            cfg_reg.sweep_step_us   <= SWEEP_STEP_RST;
            cfg_reg.hold_steps      <= HOLD_STEPS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/ssq_core.sv =====
// sweep sequencer state machine, prescaler and pulse clamping
// depends on ssq_pkg; updates its state on each beat taken from the input register
module ssq_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  ssq_pkg::ssq_in_t  in_data,
    input  ssq_pkg::cfg_t     cfg,
    output ssq_pkg::ssq_out_t result
);
    import ssq_pkg::*;

    phase_t      phase_reg,     phase_next;
    logic [7:0]  prescale_reg,  prescale_next;
    logic [9:0]  hold_reg,      hold_next;
    logic [11:0] yaw_sweep_reg, yaw_sweep_next;
    logic [11:0] pit_sweep_reg, pit_sweep_next;
    logic [11:0] yaw_now_reg,   yaw_now_next;
    logic [11:0] pit_now_reg,   pit_now_next;

    logic [7:0]  prescale_inc;
    logic [9:0]  hold_inc;
    logic        hold_done;
    logic [11:0] yaw_center_cl;
    logic [11:0] pit_center_cl;
    move_t       mv;
    logic        updated;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HOLD_YAW;
            prescale_reg  <= '0;
            hold_reg      <= '0;
            yaw_sweep_reg <= YAW_CENTER_RST;
            pit_sweep_reg <= PITCH_CENTER_RST;
            yaw_now_reg   <= YAW_CENTER_RST;
            pit_now_reg   <= PITCH_CENTER_RST;
        end else if (fire) begin
            phase_reg     <= phase_next;
            prescale_reg  <= prescale_next;
            hold_reg      <= hold_next;
            yaw_sweep_reg <= yaw_sweep_next;
            pit_sweep_reg <= pit_sweep_next;
            yaw_now_reg   <= yaw_now_next;
            pit_now_reg   <= pit_now_next;
        end
    end

    assign prescale_inc  = prescale_reg + 8'd1;
    assign hold_inc      = hold_reg + 10'd1;
    assign hold_done     = (hold_inc >= cfg.hold_steps);
    assign yaw_center_cl = clamp_us({4'b0, cfg.yaw_center_us}, cfg.yaw_min_us,
                                    cfg.yaw_max_us);
    assign pit_center_cl = clamp_us({4'b0, cfg.pitch_center_us}, cfg.pitch_min_us,
                                    cfg.pitch_max_us);

    // one move unit, fed by the axis and target of the current phase
    always_comb begin
        case (phase_reg)
            PH_YAW_UP:     mv = move_up(yaw_sweep_reg, cfg.sweep_step_us, cfg.yaw_max_us);
            PH_YAW_DOWN:   mv = move_down(yaw_sweep_reg, cfg.sweep_step_us, cfg.yaw_min_us);
            PH_YAW_BACK:   mv = move_up(yaw_sweep_reg, cfg.sweep_step_us,
                                        cfg.yaw_center_us);
            PH_PITCH_UP:   mv = move_up(pit_sweep_reg, cfg.sweep_step_us,
                                        cfg.pitch_max_us);
            PH_PITCH_DOWN: mv = move_down(pit_sweep_reg, cfg.sweep_step_us,
                                          cfg.pitch_min_us);
            PH_PITCH_BACK: mv = move_up(pit_sweep_reg, cfg.sweep_step_us,
                                        cfg.pitch_center_us);
            default:       mv = '0;
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        prescale_next  = prescale_reg;
        hold_next      = hold_reg;
        yaw_sweep_next = yaw_sweep_reg;
        pit_sweep_next = pit_sweep_reg;
        yaw_now_next   = yaw_now_reg;
        pit_now_next   = pit_now_reg;
        updated        = 1'b0;

        case (in_data.op)
            OP_TICK: begin
                prescale_next = prescale_inc;
                if (prescale_inc >= 8'(TICKS_PER_STEP)) begin
                    prescale_next = '0;
                    updated       = 1'b1;
                    case (phase_reg)
                        PH_YAW_UP, PH_YAW_DOWN, PH_YAW_BACK: begin
                            yaw_sweep_next = mv.value;
                            yaw_now_next   = clamp_us({4'b0, mv.value}, cfg.yaw_min_us,
                                                      cfg.yaw_max_us);
                            pit_now_next   = pit_center_cl;
                            if (mv.done) phase_next = phase_t'(phase_reg + 4'd1);
                        end
                        PH_PITCH_UP, PH_PITCH_DOWN, PH_PITCH_BACK: begin
                            pit_sweep_next = mv.value;
                            yaw_now_next   = yaw_center_cl;
                            pit_now_next   = clamp_us({4'b0, mv.value}, cfg.pitch_min_us,
                                                      cfg.pitch_max_us);
                            if (mv.done) phase_next = phase_t'(phase_reg + 4'd1);
                        end
                        PH_HOLD_YAW: begin
                            yaw_now_next = yaw_center_cl;
                            pit_now_next = pit_center_cl;
                            hold_next    = hold_done ? 10'd0 : hold_inc;
                            if (hold_done) begin
                                yaw_sweep_next = cfg.yaw_center_us;
                                phase_next     = PH_YAW_UP;
                            end
                        end
                        PH_HOLD_MID: begin
                            yaw_now_next = yaw_center_cl;
                            pit_now_next = pit_center_cl;
                            hold_next    = hold_done ? 10'd0 : hold_inc;
                            if (hold_done) begin
                                pit_sweep_next = cfg.pitch_center_us;
                                phase_next     = PH_PITCH_UP;
                            end
                        end
                        default: begin
                            // hold after pitch, also taken by stray phase codes
                            yaw_now_next = yaw_center_cl;
                            pit_now_next = pit_center_cl;
                            hold_next    = hold_done ? 10'd0 : hold_inc;
                            if (hold_done) phase_next = PH_HOLD_YAW;
                        end
                    endcase
                end
            end
            OP_RECENTER: begin
                phase_next     = PH_HOLD_YAW;
                prescale_next  = '0;
                hold_next      = '0;
                yaw_sweep_next = cfg.yaw_center_us;
                pit_sweep_next = cfg.pitch_center_us;
                yaw_now_next   = yaw_center_cl;
                pit_now_next   = pit_center_cl;
                updated        = 1'b1;
            end
            OP_DIRECT: begin
                yaw_now_next = clamp_us(in_data.yaw_request_us, cfg.yaw_min_us,
                                        cfg.yaw_max_us);
                pit_now_next = clamp_us(in_data.pitch_request_us, cfg.pitch_min_us,
                                        cfg.pitch_max_us);
                updated      = 1'b1;
            end
            default: begin
                updated = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.yaw_pulse_us   = yaw_now_next;
        result.pitch_pulse_us = pit_now_next;
        result.yaw_duty       = yaw_now_next[11:1];
        // times ten as x*8 + x*2
        result.pitch_compare  = {1'b0, pit_now_next, 3'b0} + {3'b0, pit_now_next, 1'b0};
        result.updated        = updated;
    end

endmodule

// ===== design/servo_sweep_sequencer_top.sv =====
// Two-axis servo pulse controller with a self-test sweep sequencer. One input beat
// (tick, recenter or direct request) is taken per clock while m_ready is high, and
// yields exactly one result beat: the beat lands in an input register, the sequencer
// state and clamped pulses are updated in a single combinational pass, and the result
// is held in an output register. Sustained rate is one beat per cycle while m_ready
// is high, set by that single state-update pass; while a result beat is stalled the
// input register can still take one more beat, after which s_ready stays low until
// the result is taken. s_ready is low during reset. Configuration is written through
// cfg_we/cfg_index/cfg_wdata and should only change while no beat is in flight.
// depends on ssq_pkg, ssq_cfg_regs, ssq_core
module servo_sweep_sequencer_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ssq_pkg::ssq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ssq_pkg::ssq_out_t m_data,
    input  logic              cfg_we,
    input  ssq_pkg::cfg_idx_t cfg_index,
    input  logic [11:0]       cfg_wdata
);
    import ssq_pkg::*;

    cfg_t     cfg;
    ssq_in_t  in_data_reg;
    logic     in_vld_reg;
    logic     in_vld_next;
    ssq_out_t out_data_reg;
    logic     out_vld_reg;
    logic     out_vld_next;
    ssq_out_t core_result;
    logic     advance;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = aresetn && (!in_vld_reg || advance);

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) in_vld_next = 1'b1;
        else if (advance)       in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance)      out_vld_next = 1'b1;
        else if (m_ready) out_vld_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_data_reg  <= s_data;
        if (advance)            out_data_reg <= core_result;
    end

    ssq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ssq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .in_data (in_data_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== design/ssq_checker.sv =====
// port-level checks of the servo sweep sequencer, bound to the top level
// depends on ssq_pkg, servo_sweep_sequencer_top_defines.svh
`include "servo_sweep_sequencer_top_defines.svh"

module ssq_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input ssq_pkg::ssq_out_t m_data
);
    import ssq_pkg::*;

    logic [11:0] last_yaw_reg;
    logic [11:0] last_pitch_reg;
    logic [15:0] pitch_times_ten;
    logic        derived_ok;
    logic        pulses_kept;

    // pulses of the last delivered beat; reset matches the power-up centers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_yaw_reg   <= YAW_CENTER_RST;
            last_pitch_reg <= PITCH_CENTER_RST;
        end else if (m_valid && m_ready) begin
            last_yaw_reg   <= m_data.yaw_pulse_us;
            last_pitch_reg <= m_data.pitch_pulse_us;
        end
    end

    assign pitch_times_ten = {4'b0, m_data.pitch_pulse_us} * 16'd10;
    assign derived_ok      = (m_data.yaw_duty == m_data.yaw_pulse_us[11:1])
                             && (m_data.pitch_compare == pitch_times_ten);
    assign pulses_kept     = (m_data.yaw_pulse_us == last_yaw_reg)
                             && (m_data.pitch_pulse_us == last_pitch_reg);

    `SSQ_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `SSQ_ASSERT(a_derived, m_valid |-> derived_ok)
    `SSQ_ASSERT(a_no_update_keeps, m_valid && !m_data.updated |-> pulses_kept)
    `SSQ_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid)

endmodule

bind servo_sweep_sequencer_top ssq_checker u_ssq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
